@@ hdl/bpfm_pkg.sv @@
package bpfm_pkg;

  localparam int FRAME_COUNT  = 16;
  localparam int PAGE_ID_BITS = 32;
  localparam int PIN_BITS     = 16;
  localparam int FRAME_BITS   = $clog2(FRAME_COUNT);
  localparam int COUNT_BITS   = FRAME_BITS + 1;

  localparam logic [1:0] KIND_FETCH = 2'd0;
  localparam logic [1:0] KIND_UNPIN = 2'd1;
  localparam logic [1:0] KIND_NEW   = 2'd2;

  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

  typedef logic [FRAME_BITS-1:0]   frame_t;
  typedef logic [PAGE_ID_BITS-1:0] page_t;

  typedef struct packed {
    logic   remove;
    logic   append;
    frame_t frame;
  } lru_cmd_t;

  typedef struct packed {
    logic   we;
    frame_t frame;
    page_t  page;
  } tag_wr_t;

endpackage

@@ hdl/bpfm_ram.sv @@
module bpfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/bpfm_tags.sv @@
module bpfm_tags (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bpfm_pkg::tag_wr_t       wr,
  input  bpfm_pkg::page_t         id,
  input  bpfm_pkg::frame_t        rd_frame,
  output logic                    hit,
  output bpfm_pkg::frame_t        hit_frame,
  output bpfm_pkg::page_t         rd_page
);
  import bpfm_pkg::*;

  page_t                  pid_r [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.frame] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      pid_r[wr.frame] <= wr.page;
    end
  end

  // lowest-indexed valid match wins
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (valid_r[i] && pid_r[i] == id) begin
        hit       = 1'b1;
        hit_frame = frame_t'(i);
      end
    end
  end

  assign rd_page = pid_r[rd_frame];

endmodule

@@ hdl/bpfm_lru.sv @@
module bpfm_lru (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bpfm_pkg::lru_cmd_t      cmd,
  output logic                    victim_ok,
  output bpfm_pkg::frame_t        victim
);
  import bpfm_pkg::*;

  frame_t                  pos_r [FRAME_COUNT];
  frame_t                  pos_nxt [FRAME_COUNT];
  logic [FRAME_COUNT-1:0]  inl_r, inl_nxt;
  logic [COUNT_BITS-1:0]   len_r, len_nxt;
  frame_t                  cpos;

  assign cpos    = pos_r[cmd.frame];

  always_comb begin
    victim_ok = 1'b0;
    victim    = '0;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      if (inl_r[i] && pos_r[i] == '0) begin
        victim_ok = 1'b1;
        victim    = frame_t'(i);
      end
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    inl_nxt = inl_r;
    len_nxt = len_r;
    if (cmd.remove && inl_r[cmd.frame]) begin
      for (int i = 0; i < FRAME_COUNT; i++) begin
        if (inl_r[i] && pos_r[i] > cpos) begin
          pos_nxt[i] = pos_r[i] - 1'b1;
        end
      end
      inl_nxt[cmd.frame] = 1'b0;
      len_nxt = len_r - 1'b1;
    end else if (cmd.append && !inl_r[cmd.frame]) begin
      pos_nxt[cmd.frame] = len_r[FRAME_BITS-1:0];
      inl_nxt[cmd.frame] = 1'b1;
      len_nxt = len_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inl_r <= '0;
      len_r <= '0;
    end else begin
      inl_r <= inl_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
  end

endmodule

@@ hdl/buffer_pool_frame_manager.sv @@
// Frame manager for a page buffer pool: tag lookup, pin counts, LRU victim choice.
// An accepted item passes the lookup, update and output states in turn; output waits while a result is held.
// A new item is accepted only in the idle state, once the previous item has left the output state.
// An item may be accepted while the previous result still waits at the output.
// Reset (synchronous, rst_n low) empties the pool, the LRU order and the id counter.
module buffer_pool_frame_manager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // page_number[31:0], mark_dirty[32], zero fill
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // success, frame_index[4:1], result_page[36:5],
                                  // write_back[37], write_back_page[69:38],
                                  // read_in[70], became_unpinned[71]
);
  import bpfm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            kind_r;
  page_t                 id_r;
  logic                  dirty_r;
  frame_t                frame_r, frame_nxt;
  logic                  ok_r, ok_nxt;
  logic                  hit_r, hit_nxt;
  logic                  vict_r, vict_nxt;
  logic [COUNT_BITS-1:0] free_r;
  page_t                 newid_r;
  logic [71:0]           res_r, res_nxt;
  logic                  outv_r;
  logic [71:0]           outd_r;

  logic                  t_hit, v_ok;
  frame_t                t_frame, victim, lru_frame;
  page_t                 rd_page;
  tag_wr_t               tag_wr;
  lru_cmd_t              lru_cmd;
  logic                  ram_we;
  logic [PIN_BITS:0]     ram_wdata, ram_rdata;
  frame_t                ram_raddr;
  logic [PIN_BITS-1:0]   pins;
  logic                  modf;

  logic                  is_fetch, is_unpin, is_new;

  assign is_fetch = kind_r == KIND_FETCH;
  assign is_unpin = kind_r == KIND_UNPIN;
  assign is_new   = kind_r == KIND_NEW;

  bpfm_tags u_tags (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (tag_wr),
    .id        (id_r),
    .rd_frame  (frame_r),
    .hit       (t_hit),
    .hit_frame (t_frame),
    .rd_page   (rd_page)
  );

  assign lru_frame = (state_r == ST_UPD) ? frame_r : frame_nxt;

  bpfm_lru u_lru (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (lru_cmd),
    .victim_ok (v_ok),
    .victim    (victim)
  );

  bpfm_ram #(.WIDTH(PIN_BITS + 1), .DEPTH(FRAME_COUNT)) u_pins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (frame_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = frame_nxt;
  assign pins      = ram_rdata[PIN_BITS-1:0];
  assign modf      = ram_rdata[PIN_BITS];

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = outv_r;
  assign out_tdata  = outd_r;

  // lookup and frame choice
  always_comb begin
    frame_nxt = frame_r;
    ok_nxt    = 1'b0;
    hit_nxt   = 1'b0;
    vict_nxt  = 1'b0;
    if (is_fetch && t_hit) begin
      frame_nxt = t_frame;
      ok_nxt    = 1'b1;
      hit_nxt   = 1'b1;
    end else if (is_unpin) begin
      frame_nxt = t_frame;
      ok_nxt    = t_hit;
      hit_nxt   = t_hit;
    end else if (is_fetch || is_new) begin
      if (!free_r[FRAME_BITS]) begin
        frame_nxt = free_r[FRAME_BITS-1:0];
        ok_nxt    = 1'b1;
      end else if (v_ok) begin
        frame_nxt = victim;
        ok_nxt    = 1'b1;
        vict_nxt  = 1'b1;
      end
    end
  end

  // update step
  always_comb begin
    tag_wr    = '{we: 1'b0, frame: frame_r, page: id_r};
    lru_cmd   = '{remove: 1'b0, append: 1'b0, frame: lru_frame};
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    res_nxt   = '0;
    if (state_r == ST_UPD && ok_r) begin
      res_nxt[0]   = 1'b1;
      res_nxt[4:1] = 4'(frame_r);
      res_nxt[36:5] = 32'(id_r);
      if (hit_r && is_fetch) begin
        ram_we    = 1'b1;
        ram_wdata = {modf, (pins != PIN_MAX) ? pins + 1'b1 : pins};
        lru_cmd.remove = 1'b1;
      end else if (hit_r) begin
        if (pins != '0) begin
          ram_we    = 1'b1;
          ram_wdata = {modf | dirty_r, pins - 1'b1};
          if (pins == PIN_BITS'(1)) begin
            lru_cmd.append = 1'b1;
            res_nxt[71]    = 1'b1;
          end
        end
      end else begin
        ram_we         = 1'b1;
        ram_wdata      = {is_new, PIN_BITS'(1)};
        tag_wr.we      = 1'b1;
        tag_wr.page    = is_new ? newid_r : id_r;
        lru_cmd.remove = vict_r;
        res_nxt[36:5]  = 32'(tag_wr.page);
        res_nxt[70]    = is_fetch;
        if (vict_r && modf) begin
          res_nxt[37]    = 1'b1;
          res_nxt[69:38] = 32'(rd_page);
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_OUT;
      ST_OUT:  if (!outv_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      free_r  <= '0;
      newid_r <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_UPD && ok_r && !hit_r) begin
        if (!vict_r) free_r <= free_r + 1'b1;
        if (is_new)  newid_r <= newid_r + 1'b1;
      end
      if (state_r == ST_OUT && (!outv_r || out_tready)) begin
        outv_r <= 1'b1;
      end else if (out_tready) begin
        outv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r  <= in_tuser;
      id_r    <= in_tdata[31:0];
      dirty_r <= in_tdata[32];
    end
    if (state_r == ST_LOOK) begin
      frame_r <= frame_nxt;
      ok_r    <= ok_nxt;
      hit_r   <= hit_nxt;
      vict_r  <= vict_nxt;
    end
    if (state_r == ST_UPD) begin
      res_r <= res_nxt;
    end
    if (state_r == ST_OUT && (!outv_r || out_tready)) begin
      outd_r <= res_r;
    end
  end

endmodule
